### design/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg: shared types and constants of the comment/string stripper
// Marker packing, payload structs, parser state and the suffix match.
// ----------------------------------------------------------------------------
package css_pkg;

	localparam int MARK_LEN  = 3;              // longest marker, in characters
	localparam int CHAR_BITS = 16;             // bits compared per character
	localparam int HOLD      = MARK_LEN - 1;   // characters held back in code

	// Commands
	localparam logic [1:0] CMD_CHAR  = 2'd0;
	localparam logic [1:0] CMD_EOL   = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;

	// Parser modes
	localparam logic [1:0] MODE_CODE  = 2'd0;
	localparam logic [1:0] MODE_LINE  = 2'd1;
	localparam logic [1:0] MODE_BLOCK = 2'd2;
	localparam logic [1:0] MODE_STR   = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_LINE_MARKER = 3'd0;
	localparam logic [2:0] REG_BLOCK_OPEN  = 3'd1;
	localparam logic [2:0] REG_BLOCK_CLOSE = 3'd2;
	localparam logic [2:0] REG_QUOTE_A     = 3'd3;
	localparam logic [2:0] REG_ESCAPE_A    = 3'd4;
	localparam logic [2:0] REG_QUOTE_B     = 3'd5;
	localparam logic [2:0] REG_ESCAPE_B    = 3'd6;

	typedef logic [2:0][15:0] win_t;
	typedef logic [1:0][15:0] hist_t;

	// Same layout as the 50-bit register: length on top, character 0 lowest
	typedef struct packed {
		logic [1:0]  len;
		win_t        ch;
	} mark_t;

	typedef struct packed {
		mark_t line_marker;
		mark_t block_open;
		mark_t block_close;
		mark_t quote_a;
		mark_t escape_a;
		mark_t quote_b;
		mark_t escape_b;
	} cfg_set_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] in_char;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] out_char;
		logic        comment_seen;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] mode;
		hist_t      hist;
		logic [1:0] hcnt;
		logic       pair;
		logic       seen;
	} state_t;

	localparam state_t STATE_RST = '{mode: MODE_CODE, hist: '0, hcnt: 2'd0,
		pair: 1'b0, seen: 1'b0};

	typedef struct packed {
		logic        kind;
		logic [15:0] ch;
	} ent_t;

	typedef struct packed {
		state_t          nxt;
		logic [1:0]      cnt;
		logic [2:0][16:0] ent;
	} step_out_t;

	// True when marker m ends at the last of the n window characters
	function automatic logic suffix_match(mark_t m, win_t win, logic [1:0] n);
		logic       hit;
		logic [1:0] idx;
		hit = (m.len != 2'd0) && (m.len <= n);
		for (int i = 0; i < MARK_LEN; i++) begin
			idx = n - m.len + 2'(i);
			if (2'(i) < m.len && idx < 2'(MARK_LEN)) begin
				if (m.ch[i][CHAR_BITS-1:0] != win[idx][CHAR_BITS-1:0])
					hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage

### design/css_step.sv
// ----------------------------------------------------------------------------
// css_step: next-state and result logic for one event
// Combinational; gives up to three results and the parser state after them.
// ----------------------------------------------------------------------------
module css_step (
	input  css_pkg::item_t     item,
	input  css_pkg::state_t    st,
	input  css_pkg::cfg_set_t  cfg,
	output css_pkg::step_out_t so
);

	css_pkg::win_t     win;
	css_pkg::hist_t    tail_h;
	logic [1:0]        tail_n;
	logic [1:0]        n;
	logic              m_line, m_blk, m_qa, m_qb, m_close, m_q, m_e;
	logic [1:0]        mlen;
	css_pkg::ent_t     ent [3];

	always_comb begin
		n      = st.hcnt + 2'd1;
		win[2] = item.in_char;
		win[1] = (st.hcnt == 2'd2) ? st.hist[1] : item.in_char;
		win[0] = (st.hcnt == 2'd0) ? item.in_char : st.hist[0];

		m_line  = css_pkg::suffix_match(cfg.line_marker, win, n);
		m_blk   = css_pkg::suffix_match(cfg.block_open, win, n);
		m_qa    = css_pkg::suffix_match(cfg.quote_a, win, n);
		m_qb    = css_pkg::suffix_match(cfg.quote_b, win, n);
		m_close = css_pkg::suffix_match(cfg.block_close, win, n);
		m_q     = css_pkg::suffix_match(st.pair ? cfg.quote_b : cfg.quote_a, win, n);
		m_e     = css_pkg::suffix_match(st.pair ? cfg.escape_b : cfg.escape_a, win, n);
		mlen    = m_line ? cfg.line_marker.len : cfg.block_open.len;

		// Keep the newest characters, at most HOLD of them
		if (n > 2'(css_pkg::HOLD)) begin
			tail_h = {win[2], win[1]};
			tail_n = 2'(css_pkg::HOLD);
		end else begin
			tail_h = {win[1], win[0]};
			tail_n = n;
		end

		so.nxt = st;
		so.cnt = 2'd0;
		for (int i = 0; i < 3; i++)
			ent[i] = '{kind: 1'b0, ch: win[i]};

		unique case (item.cmd)
			css_pkg::CMD_CHAR: begin
				unique case (st.mode)
					css_pkg::MODE_CODE: begin
						if (m_line || m_blk) begin
							so.cnt      = n - mlen;
							so.nxt.seen = 1'b1;
							so.nxt.mode = m_line ? css_pkg::MODE_LINE : css_pkg::MODE_BLOCK;
							so.nxt.hist = '0;
							so.nxt.hcnt = 2'd0;
						end else if (m_qa || m_qb) begin
							so.cnt      = n;
							so.nxt.pair = !m_qa;
							so.nxt.mode = css_pkg::MODE_STR;
							so.nxt.hist = '0;
							so.nxt.hcnt = 2'd0;
						end else begin
							// Release the oldest character once the window is full
							so.cnt      = (n > 2'(css_pkg::HOLD)) ? 2'd1 : 2'd0;
							so.nxt.hist = tail_h;
							so.nxt.hcnt = tail_n;
						end
					end
					css_pkg::MODE_LINE: ;
					css_pkg::MODE_BLOCK: begin
						so.nxt.seen = 1'b1;
						if (m_close) begin
							so.nxt.mode = css_pkg::MODE_CODE;
							so.nxt.hist = '0;
							so.nxt.hcnt = 2'd0;
						end else begin
							so.nxt.hist = tail_h;
							so.nxt.hcnt = tail_n;
						end
					end
					css_pkg::MODE_STR: begin
						so.cnt    = 2'd1;
						ent[0].ch = item.in_char;
						if (m_q && !m_e) begin
							so.nxt.mode = css_pkg::MODE_CODE;
							so.nxt.hist = '0;
							so.nxt.hcnt = 2'd0;
						end else begin
							so.nxt.hist = tail_h;
							so.nxt.hcnt = tail_n;
						end
					end
				endcase
			end
			css_pkg::CMD_EOL: begin
				// Flush held characters in code, then mark the line end
				so.cnt = (st.mode == css_pkg::MODE_CODE) ? st.hcnt : 2'd0;
				ent[so.cnt] = '{kind: 1'b1, ch: 16'd0};
				so.cnt = so.cnt + 2'd1;
				if (st.mode == css_pkg::MODE_LINE)
					so.nxt.mode = css_pkg::MODE_CODE;
				so.nxt.hist = '0;
				so.nxt.hcnt = 2'd0;
			end
			css_pkg::CMD_RESET: begin
				so.nxt = css_pkg::STATE_RST;
			end
			default: ;
		endcase

		for (int i = 0; i < 3; i++)
			so.ent[i] = ent[i];
	end

endmodule

### design/comment_string_stripper_core.sv
// ----------------------------------------------------------------------------
// comment_string_stripper_core: source comment stripper
// Removes line and block comments from a stream of character events.
// ----------------------------------------------------------------------------
// Usage:
//  - src channel (src_valid/src_stall/src_data) takes one event per transfer:
//    a character, an end of line or a parser reset.
//  - dst channel (dst_valid/dst_stall/dst_data) gives the kept characters and
//    line-end marks; last flags the final result of an event.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the seven
//    marker registers; it is always ready. Write only while the block is idle.
//  - Each event passes through the input register and then the result
//    register before its first result is on dst. An event gives 0 to 3
//    results, which leave one per transfer on the single result port, so
//    while dst_stall is low the block takes one event per cycle for events
//    with at most one result; an event with more results waits in the
//    input register until the result register can take its batch.
//  - Reset clears the parser state, all marker registers and both channels.
//  - While dst_stall is high the result register holds; the input register
//    keeps taking one more event, then src_stall rises once it must wait.
// ----------------------------------------------------------------------------
module comment_string_stripper_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  css_pkg::item_t    src_data,
	output logic              dst_valid,
	input  logic              dst_stall,
	output css_pkg::result_t  dst_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [49:0]       cfg_data
);

	css_pkg::cfg_set_t  cfg_q;
	css_pkg::state_t    state_q;
	css_pkg::item_t     item_s1;
	logic               valid_s1;
	css_pkg::result_t   res_q [3];
	logic [1:0]         rem_q;
	css_pkg::step_out_t so;
	logic               take;
	logic               free;
	logic               advance;
	logic               src_xfer;

	assign cfg_ready = 1'b1;

	// Marker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				css_pkg::REG_LINE_MARKER: cfg_q.line_marker <= cfg_data;
				css_pkg::REG_BLOCK_OPEN:  cfg_q.block_open  <= cfg_data;
				css_pkg::REG_BLOCK_CLOSE: cfg_q.block_close <= cfg_data;
				css_pkg::REG_QUOTE_A:     cfg_q.quote_a     <= cfg_data;
				css_pkg::REG_ESCAPE_A:    cfg_q.escape_a    <= cfg_data;
				css_pkg::REG_QUOTE_B:     cfg_q.quote_b     <= cfg_data;
				css_pkg::REG_ESCAPE_B:    cfg_q.escape_b    <= cfg_data;
				default: ;
			endcase
		end
	end

	css_step u_step (
		.item (item_s1),
		.st   (state_q),
		.cfg  (cfg_q),
		.so   (so)
	);

	// Result register drains one entry per transfer
	assign dst_valid = (rem_q != 2'd0);
	assign dst_data  = res_q[0];
	assign take      = dst_valid && !dst_stall;
	// The result register can take a new batch when it is empty or empties this cycle
	assign free      = (rem_q == 2'd0) || (rem_q == 2'd1 && take);
	// An event with no results never waits for the result register
	assign advance   = valid_s1 && (so.cnt == 2'd0 || free);
	assign src_stall = valid_s1 && !advance;
	assign src_xfer  = src_valid && !src_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_xfer)
			item_s1 <= src_data;
	end

	// Parser state advances with each event that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= css_pkg::STATE_RST;
		end else if (advance) begin
			state_q <= so.nxt;
		end
	end

	// Result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (advance && so.cnt != 2'd0) begin
			rem_q <= so.cnt;
		end else if (take) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	// Result entries: load a batch, or shift toward the head on a transfer
	always_ff @(posedge clk) begin
		if (advance && so.cnt != 2'd0) begin
			for (int i = 0; i < 3; i++) begin
				res_q[i].kind         <= so.ent[i][16];
				res_q[i].out_char     <= so.ent[i][15:0];
				res_q[i].comment_seen <= so.nxt.seen;
				res_q[i].last         <= (2'(i) + 2'd1 == so.cnt);
			end
		end else if (take) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule
